// File: rtl/mrr_pkg.sv
// Package for the Miller-Rabin round core: widths, state codes, multiplier control.
// No dependencies.
package mrr_pkg;
    localparam int NUMBER_BITS_DEF = 32;
    localparam int FIELD_BITS = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STRIP,
        ST_POW_SQ,
        ST_POW_MUL,
        ST_CHECK,
        ST_LOOP_SQ,
        ST_LOOP_CHK,
        ST_DONE
    } mrr_state_t;

    typedef struct packed {
        logic start;
        logic busy;
    } mrr_mul_ctl_t;
endpackage

// File: rtl/mrr_stream_if.sv
// Valid/ready channel carrying a request payload of parameter width.
// Depends on nothing.
interface mrr_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/mrr_modmul.sv
// Bit-serial modular multiplier: p = a*b mod m, one bit of b per cycle.
// Depends on mrr_pkg.
module mrr_modmul
    import mrr_pkg::*;
#(
    parameter int NB = NUMBER_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  mrr_mul_ctl_t  ctl_in,
    input  logic [NB-1:0] a,
    input  logic [NB-1:0] b,
    input  logic [NB-1:0] m,
    output logic          done,
    output logic [NB-1:0] p
);
    localparam int CW = $clog2(NB + 1);
    logic [NB-1:0] acc_reg, acc_next;
    logic [NB-1:0] b_reg, b_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [NB+1:0] dbl, dsub, add, asub;

    // Horner step: acc = 2*acc (+a), reduced after the doubling and again after the add
    always_comb begin
        dbl  = {1'b0, acc_reg, 1'b0};
        dsub = (dbl >= {2'b00, m}) ? dbl - {2'b00, m} : dbl;
        add  = dsub + (b_reg[NB-1] ? {2'b00, a} : '0);
        asub = (add >= {2'b00, m}) ? add - {2'b00, m} : add;
        acc_next  = acc_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (ctl_in.start) begin
            acc_next = '0;
            b_next   = b;
            cnt_next = CW'(NB);
            run_next = 1'b1;
        end else if (run_reg) begin
            acc_next = asub[NB-1:0];
            b_next   = {b_reg[NB-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        acc_reg <= acc_next;
        b_reg   <= b_next;
    end

    // Flag the cycle after the last step, when the product sits in acc_reg
    assign done = done_reg;
    assign p    = acc_reg;

`ifndef NO_ASSERTIONS
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ctl_in.busy) else $error("multiplier done while idle");
    a_run_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> cnt_reg != '0) else $error("running with zero count");
    a_done_stop: assert property (@(posedge clk) disable iff (!rst_n)
        done && !ctl_in.start |=> !run_reg) else $error("multiplier ran on");
`endif
endmodule

// File: rtl/miller_rabin_round_core.sv
// Top level of the Miller-Rabin round core: sequencer and result register.
// Depends on mrr_pkg, mrr_stream_if and mrr_modmul.
//
// One request at a time. Each modular product runs through the bit-serial
// multiplier; a round runs the witness reduction, one square per exponent bit,
// multiplies for the set bits of the odd part and the final squarings, plus
// the strip steps and one check step per squaring. Reducing the witness takes
// one product (1*a mod n, bits of a shifted in). Candidates below 5 settle
// without the multiplier. The verdict is held in an output register until
// taken, so the next request can be taken meanwhile.
module miller_rabin_round_core
    import mrr_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    mrr_stream_if.sink   req_in,
    mrr_stream_if.source res_out
);
    localparam int NB = NUMBER_BITS;
    localparam int CW = $clog2(NB + 1);
    localparam int BW = $clog2(NB);

    mrr_state_t     state_reg, state_next;
    logic [NB-1:0]  n_reg, n_next, a_reg, a_next, x_reg, x_next;
    logic [NB-1:0]  d_reg, d_next;
    logic [BW-1:0]  bit_reg, bit_next;
    logic [CW-1:0]  tz_reg, tz_next;
    logic           pp_reg, pp_next, cc_reg, cc_next, ov_reg, ov_next;
    logic           res_pp_reg, res_pp_next, res_cc_reg, res_cc_next;
    logic [NB-1:0]  mul_a, mul_b, prod;
    logic           mul_done;
    mrr_mul_ctl_t   mctl;
    logic [NB-1:0]  cand, wit, last;

    assign cand = req_in.data[NB-1:0];
    assign wit  = req_in.data[FIELD_BITS+NB-1:FIELD_BITS];
    assign last = n_reg - 1'b1;

    mrr_modmul #(.NB(NB)) u_mul (
        .clk(clk), .rst_n(rst_n), .ctl_in(mctl),
        .a(mul_a), .b(mul_b), .m(n_reg), .done(mul_done), .p(prod)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk) begin
        n_reg <= n_next; a_reg <= a_next; x_reg <= x_next; d_reg <= d_next;
        bit_reg <= bit_next; tz_reg <= tz_next; pp_reg <= pp_next; cc_reg <= cc_next;
        res_pp_reg <= res_pp_next; res_cc_reg <= res_cc_next;
    end

    // Sequence strip, reduce, square-and-multiply (MSB first), then squaring loop
    always_comb begin
        state_next = state_reg;
        n_next = n_reg; a_next = a_reg; x_next = x_reg; d_next = d_reg;
        bit_next = bit_reg; tz_next = tz_reg; pp_next = pp_reg; cc_next = cc_reg;
        res_pp_next = res_pp_reg; res_cc_next = res_cc_reg;
        ov_next = ov_reg;
        mctl.start = 1'b0;
        mctl.busy  = 1'b0;
        mul_a = x_reg;
        mul_b = x_reg;
        req_in.ready = (state_reg == ST_IDLE);
        if (ov_reg && res_out.ready) ov_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (req_in.valid) begin
                    n_next = cand; a_next = wit;
                    if (cand <= NB'(1) || cand == NB'(4)) begin
                        pp_next = 1'b0; cc_next = 1'b1; state_next = ST_DONE;
                    end else if (cand <= NB'(3)) begin
                        pp_next = 1'b1; cc_next = 1'b1; state_next = ST_DONE;
                    end else begin
                        cc_next = 1'b0;
                        d_next = cand - 1'b1;
                        tz_next = '0;
                        state_next = ST_STRIP;
                    end
                end
            end
            ST_STRIP: begin
                if (!d_reg[0]) begin
                    d_next = {1'b0, d_reg[NB-1:1]};
                    tz_next = tz_reg + 1'b1;
                end else begin
                    mul_a = NB'(1); mul_b = a_reg;
                    mctl.start = 1'b1;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                mctl.busy = 1'b1;
                mul_a = NB'(1); mul_b = a_reg;
                if (mul_done) begin
                    a_next = prod;
                    x_next = NB'(1);
                    bit_next = BW'(NB - 1);
                    mctl.start = 1'b1;
                    mul_a = NB'(1); mul_b = NB'(1);
                    state_next = ST_POW_SQ;
                end
            end
            ST_POW_SQ: begin
                mctl.busy = 1'b1;
                if (mul_done) begin
                    x_next = prod;
                    mctl.start = 1'b1;
                    if (d_reg[bit_reg]) begin
                        mul_a = prod; mul_b = a_reg;
                        state_next = ST_POW_MUL;
                    end else if (bit_reg == '0) begin
                        mctl.start = 1'b0;
                        state_next = ST_CHECK;
                    end else begin
                        mul_a = prod; mul_b = prod;
                        bit_next = bit_reg - 1'b1;
                    end
                end
            end
            ST_POW_MUL: begin
                mctl.busy = 1'b1;
                mul_a = x_reg; mul_b = a_reg;
                if (mul_done) begin
                    x_next = prod;
                    if (bit_reg == '0) begin
                        state_next = ST_CHECK;
                    end else begin
                        mctl.start = 1'b1;
                        mul_a = prod; mul_b = prod;
                        bit_next = bit_reg - 1'b1;
                        state_next = ST_POW_SQ;
                    end
                end
            end
            ST_CHECK: begin
                if (x_reg == NB'(1) || x_reg == last) begin
                    pp_next = 1'b1; state_next = ST_DONE;
                end else if (tz_reg == '0) begin
                    pp_next = 1'b0; state_next = ST_DONE;
                end else begin
                    mctl.start = 1'b1;
                    state_next = ST_LOOP_SQ;
                end
            end
            ST_LOOP_SQ: begin
                mctl.busy = 1'b1;
                if (mul_done) begin
                    x_next = prod;
                    tz_next = tz_reg - 1'b1;
                    state_next = ST_LOOP_CHK;
                end
            end
            ST_LOOP_CHK: begin
                if (x_reg == NB'(1)) begin
                    pp_next = 1'b0; state_next = ST_DONE;
                end else if (x_reg == last) begin
                    pp_next = 1'b1; state_next = ST_DONE;
                end else if (tz_reg == '0) begin
                    pp_next = 1'b0; state_next = ST_DONE;
                end else begin
                    mctl.start = 1'b1;
                    state_next = ST_LOOP_SQ;
                end
            end
            ST_DONE: begin
                // hand the verdict over once the output register is free
                if (!ov_reg || res_out.ready) begin
                    ov_next = 1'b1;
                    res_pp_next = pp_reg;
                    res_cc_next = cc_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign res_out.valid = ov_reg;
    assign res_out.data  = {res_cc_reg, res_pp_reg};

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_in.ready |-> state_reg == ST_IDLE) else $error("accept while busy");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_out.valid && !res_out.ready |=> res_out.valid && $stable(res_out.data))
        else $error("result dropped");
    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !mctl.busy) else $error("multiplier busy in idle");
`endif
endmodule
